>>> src/hysteresis_level_classifier_macros.svh
// Assertion macros for the hysteresis level classifier.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef HYSTERESIS_LEVEL_CLASSIFIER_MACROS_SVH
`define HYSTERESIS_LEVEL_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define HLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hlc: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define HLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hlc: next-cycle check failed");

`endif

>>> src/hlc_pkg.sv
// Shared types and constants for the hysteresis level classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package hlc_pkg;

    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned MARGIN_W = 8;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned CFG_W    = 16;

    typedef logic [1:0]          t_level;
    typedef logic [LIMIT_W-1:0]  t_limit;
    typedef logic [MARGIN_W-1:0] t_margin;
    typedef logic [COUNT_W-1:0]  t_count;

    // Reported levels
    localparam t_level LVL_GOOD     = 2'd0;
    localparam t_level LVL_MODERATE = 2'd1;
    localparam t_level LVL_POOR     = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BAND0  = 3'd0,
        CFG_BAND1  = 3'd1,
        CFG_BAND2  = 3'd2,
        CFG_BAND3  = 3'd3,
        CFG_RISE   = 3'd4,
        CFG_FALL   = 3'd5,
        CFG_HOLD   = 3'd6
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam t_limit  RST_BAND0 = 16'd35;
    localparam t_limit  RST_BAND1 = 16'd75;
    localparam t_limit  RST_BAND2 = 16'd115;
    localparam t_limit  RST_BAND3 = 16'd150;
    localparam t_margin RST_RISE  = 8'd5;
    localparam t_margin RST_FALL  = 8'd2;
    localparam t_count  RST_HOLD  = 6'd30;

    typedef struct packed {
        t_limit  band0_limit;
        t_limit  band1_limit;
        t_limit  band2_limit;
        t_limit  band3_limit;
        t_margin rise_margin;
        t_margin fall_margin;
        t_count  hold_count;
    } t_cfg;

    // Band lookup result: raw level and the band's edges
    typedef struct packed {
        t_level level;
        t_limit lo;
        t_limit hi;
    } t_band;

endpackage

`default_nettype wire

>>> src/hysteresis_level_classifier.sv
// A word is captured in the input register; its level is then registered in the result register that drives o_level.
// Throughput: one reading per cycle; the level/persistence update is a single
// compare-and-count step on the stored state between the input and result registers.
// A stalled result holds both registers, so the input stalls once both are full.
// Reset (synchronous, active low) empties both registers, clears the stored previous
// level and persistence count to zero and loads the configuration defaults.
`default_nettype none

`include "hysteresis_level_classifier_macros.svh"

module hysteresis_level_classifier
    import hlc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // reading channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [15:0]      i_reading,
    // level channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [1:0]            o_level,
    // configuration write port
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    t_cfg   w_cfg;
    t_band  w_band;

    logic   r_in_valid;
    t_limit r_in_reading;
    logic   r_out_valid;
    t_level r_out_level;
    t_level r_prev_level;
    t_count r_persist_count;

    t_level n_level;
    t_count n_persist_count;

    logic   w_out_ready;
    logic   w_step;
    logic   w_changed;
    logic   w_held;

    hlc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Handshake: result register frees up when empty or being taken
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_reading <= i_reading;
        end
    end

    hlc_band u_band (
        .i_reading (r_in_reading),
        .i_cfg     (w_cfg),
        .o_band    (w_band)
    );

    // Hysteresis and persistence; edge sums are 17 bits so nothing wraps
    assign w_changed = (w_band.level != r_prev_level);

    always_comb begin
        if (w_band.level > r_prev_level) begin
            w_held = ({1'b0, r_in_reading} <
                      ({1'b0, w_band.lo} + {9'd0, w_cfg.rise_margin}));
        end else begin
            w_held = (({1'b0, r_in_reading} + {9'd0, w_cfg.fall_margin}) >
                      {1'b0, w_band.hi});
        end
    end

    always_comb begin
        n_level         = w_band.level;
        n_persist_count = r_persist_count;
        if (w_changed) begin
            priority if (w_held) begin
                n_persist_count = '0;
                n_level         = r_prev_level;
            end else if (r_persist_count < w_cfg.hold_count) begin
                n_persist_count = r_persist_count + 6'd1;
                n_level         = r_prev_level;
            end else begin
                // persisted long enough: new level taken, count stays
                n_level         = w_band.level;
            end
        end else begin
            n_persist_count = '0;
        end
    end

    // Filter state advances once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level    <= LVL_GOOD;
            r_persist_count <= '0;
        end else if (w_step) begin
            r_prev_level    <= n_level;
            r_persist_count <= n_persist_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_level <= n_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;

    // Checks
    `HLC_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)
    `HLC_ASSERT_NXT(a_state_holds_idle, i_clk, i_rst_n, !w_step, $stable(r_prev_level) && $stable(r_persist_count))
    `HLC_ASSERT_NXT(a_result_tracks_state, i_clk, i_rst_n, w_step, r_out_valid && (r_out_level == r_prev_level))
    `HLC_ASSERT_NXT(a_switch_keeps_count, i_clk, i_rst_n, w_step && w_changed && (n_level == w_band.level), $stable(r_persist_count))

endmodule

`default_nettype wire

>>> src/hlc_cfg_regs.sv
// Configuration register file of the hysteresis level classifier.
// Depends on hlc_pkg for the register layout, indexes and reset values.
`default_nettype none

module hlc_cfg_regs
    import hlc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; indexes past the last register are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BAND0: n_cfg.band0_limit = i_cfg_wdata[LIMIT_W-1:0];
                CFG_BAND1: n_cfg.band1_limit = i_cfg_wdata[LIMIT_W-1:0];
                CFG_BAND2: n_cfg.band2_limit = i_cfg_wdata[LIMIT_W-1:0];
                CFG_BAND3: n_cfg.band3_limit = i_cfg_wdata[LIMIT_W-1:0];
                CFG_RISE:  n_cfg.rise_margin = i_cfg_wdata[MARGIN_W-1:0];
                CFG_FALL:  n_cfg.fall_margin = i_cfg_wdata[MARGIN_W-1:0];
                CFG_HOLD:  n_cfg.hold_count  = i_cfg_wdata[COUNT_W-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band0_limit <= RST_BAND0;
            r_cfg.band1_limit <= RST_BAND1;
            r_cfg.band2_limit <= RST_BAND2;
            r_cfg.band3_limit <= RST_BAND3;
            r_cfg.rise_margin <= RST_RISE;
            r_cfg.fall_margin <= RST_FALL;
            r_cfg.hold_count  <= RST_HOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/hlc_band.sv
// Band lookup: compares a reading against the limit cascade.
// Depends on hlc_pkg for the configuration and band types.
`default_nettype none

module hlc_band
    import hlc_pkg::*;
(
    input  wire t_limit i_reading,
    input  wire t_cfg   i_cfg,
    output t_band       o_band
);

    // Cascade in order as written; misordered limits are not sorted
    always_comb begin
        priority if (i_reading <= i_cfg.band0_limit) begin
            o_band.level = LVL_GOOD;
            o_band.lo    = i_cfg.band0_limit;
            o_band.hi    = i_cfg.band0_limit;
        end else if (i_reading <= i_cfg.band1_limit) begin
            o_band.level = LVL_MODERATE;
            o_band.lo    = i_cfg.band0_limit;
            o_band.hi    = i_cfg.band1_limit;
        end else if (i_reading <= i_cfg.band2_limit) begin
            o_band.level = LVL_MODERATE;
            o_band.lo    = i_cfg.band1_limit;
            o_band.hi    = i_cfg.band2_limit;
        end else begin
            o_band.level = LVL_POOR;
            o_band.lo    = i_cfg.band2_limit;
            o_band.hi    = i_cfg.band3_limit;
        end
    end

endmodule

`default_nettype wire
